[rtl/dcrt_pkg.sv]
// Package for the duty cycle rate throttle: shared widths, reset values,
// item and phase codes, and the controller/datapath command and status types.
// No dependencies.
`default_nettype none

package dcrt_pkg;

	// Default width of the cumulative byte count.
	localparam int BYTE_COUNT_BITS_DEF = 48;

	// Fixed field widths.
	localparam int LIMIT_W   = 32;
	localparam int WIN_W     = 16;
	localparam int ELAPSED_W = 31;
	localparam int KIND_W    = 2;

	// Output tdata: run_enable, on_ticks, off_ticks, padded to whole bytes.
	localparam int M_TDATA_W = ((1 + 2 * WIN_W + 7) / 8) * 8;

	// Saturation value of the elapsed tick counter and the expected time.
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 31'h7FFF_FFFF;

	// Register reset values.
	localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST  = 32'd0;
	localparam logic [WIN_W-1:0]   CYCLE_PERIOD_RST = 16'd4500;
	localparam logic [WIN_W-1:0]   RECHECK_RST      = 16'd500;
	localparam logic [WIN_W-1:0]   START_DELAY_RST  = 16'd50;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_SPEED_LIMIT  = 2'd0;
	localparam logic [1:0] REG_CYCLE_PERIOD = 2'd1;
	localparam logic [1:0] REG_RECHECK      = 2'd2;
	localparam logic [1:0] REG_START_DELAY  = 2'd3;

	// Input item kinds; the fourth code is ignored.
	localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

	// Throttle phases.
	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_WAIT   = 2'd1,
		PH_SUSP   = 2'd2,
		PH_RESUME = 2'd3
	} phase_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic eval;
		logic mul1;
		logic div_start;
		logic den_sel;
		logic cmp;
		logic mul2;
		logic win;
		logic load_out;
	} dcrt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_check;
		logic div_busy;
		logic throttle;
	} dcrt_sts_t;

endpackage

`default_nettype wire

[rtl/duty_cycle_rate_throttle_core.sv]
// Duty cycle rate throttle, top level: configuration registers on an APB
// port, stream input and output, controller and datapath instances.
// Depends on dcrt_pkg, dcrt_ctrl, dcrt_dp (and through it dcrt_div).
//
// The block gates a transfer's run enable so that it keeps to a byte per
// second limit. Each input request is a start, a one millisecond tick or a
// finish (tuser), with the cumulative byte count in tdata; each request gives
// exactly one result. A request that causes no rate check goes through the
// steps accept, evaluate and load result; the load waits while the output
// register holds a result not yet taken. A tick that runs a rate check passes
// one division in a shared one bit per cycle serial divider, and a second one
// when the rate is over the limit. The numerator width of a division is
// BYTE_COUNT_BITS + 10 but at least 47.
// The block works on one request at a time; a new request is accepted as soon
// as the previous result sits in the output register, even if that result has
// not been taken yet. The user must write configuration only while no request
// is in work; the block itself does not enforce this.
`default_nettype none

module duty_cycle_rate_throttle_core import dcrt_pkg::*; #(
	parameter int BYTE_COUNT_BITS = BYTE_COUNT_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// Configuration port.
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [3:0]                            paddr,
	input  wire logic [31:0]                           pwdata,
	output logic [31:0]                                prdata,
	output logic                                       pready,
	// Input stream.
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	// tdata: byte_count, zero padded to whole bytes
	input  wire logic [((BYTE_COUNT_BITS+7)/8)*8-1:0] s_axis_tdata,
	// tuser: kind
	input  wire logic [KIND_W-1:0]                     s_axis_tuser,
	// Output stream.
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// tdata: run_enable, on_ticks, off_ticks, zero padded
	output logic [M_TDATA_W-1:0]                       m_axis_tdata,
	// tuser: check_done
	output logic [0:0]                                 m_axis_tuser
);

	logic [LIMIT_W-1:0] speed_limit_q;
	logic [WIN_W-1:0]   cycle_period_q;
	logic [WIN_W-1:0]   recheck_q;
	logic [WIN_W-1:0]   start_delay_q;
	logic               cfg_wr;
	logic [1:0]         reg_idx;

	dcrt_cmd_t          cmd;
	dcrt_sts_t          sts;
	logic               run_enable;
	logic               check_done;
	logic [WIN_W-1:0]   on_ticks;
	logic [WIN_W-1:0]   off_ticks;

	// Configuration registers.
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_limit_q  <= SPEED_LIMIT_RST;
			cycle_period_q <= CYCLE_PERIOD_RST;
			recheck_q      <= RECHECK_RST;
			start_delay_q  <= START_DELAY_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SPEED_LIMIT:  speed_limit_q  <= pwdata;
				REG_CYCLE_PERIOD: cycle_period_q <= pwdata[WIN_W-1:0];
				REG_RECHECK:      recheck_q      <= pwdata[WIN_W-1:0];
				REG_START_DELAY:  start_delay_q  <= pwdata[WIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (reg_idx)
			REG_SPEED_LIMIT:  prdata = speed_limit_q;
			REG_CYCLE_PERIOD: prdata = {16'd0, cycle_period_q};
			REG_RECHECK:      prdata = {16'd0, recheck_q};
			REG_START_DELAY:  prdata = {16'd0, start_delay_q};
			default:          prdata = '0;
		endcase
	end

	dcrt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	dcrt_dp #(
		.BYTE_COUNT_BITS (BYTE_COUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_kind      (s_axis_tuser),
		.in_bytes     (s_axis_tdata[BYTE_COUNT_BITS-1:0]),
		.speed_limit  (speed_limit_q),
		.cycle_period (cycle_period_q),
		.recheck      (recheck_q),
		.start_delay  (start_delay_q),
		.run_enable   (run_enable),
		.check_done   (check_done),
		.on_ticks     (on_ticks),
		.off_ticks    (off_ticks)
	);

	// Result packing.
	assign m_axis_tdata = {{(M_TDATA_W - 1 - 2 * WIN_W){1'b0}}, off_ticks, on_ticks, run_enable};
	assign m_axis_tuser = check_done;

endmodule

`default_nettype wire

[rtl/dcrt_div.sv]
// Serial restoring divider, one quotient bit per cycle, quotient saturated.
// Used by the throttle datapath for both divisions of a rate check.
// Depends on nothing but its parameters.
`default_nettype none

module dcrt_div #(
	parameter int NUM_W = 58,
	parameter int DEN_W = 32,
	parameter int QUO_W = 31
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  busy,
	output logic [QUO_W-1:0]      quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic             ovf_q;

	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_diff;
	logic             ge;
	logic [DEN_W-1:0] rem_next;

	// One restoring step: bring down the next numerator bit and try to subtract.
	assign rem_sh   = {rem_q, num_q[NUM_W-1]};
	assign rem_diff = rem_sh - {1'b0, den_q};
	assign ge       = (rem_sh >= {1'b0, den_q});
	assign rem_next = ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Operand, remainder and quotient registers. Quotient bits that move past
	// the top of the quotient set the overflow flag.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= rem_next;
			quo_q <= {quo_q[QUO_W-2:0], ge};
			ovf_q <= ovf_q | quo_q[QUO_W-1];
		end
	end

	assign busy = busy_q;
	assign quo  = ovf_q ? '1 : quo_q;

endmodule

`default_nettype wire

[rtl/dcrt_dp.sv]
// Datapath of the duty cycle rate throttle: throttle state, rate check
// arithmetic with the serial divider, and the result register.
// Depends on dcrt_pkg and dcrt_div.
`default_nettype none

module dcrt_dp import dcrt_pkg::*; #(
	parameter int BYTE_COUNT_BITS = BYTE_COUNT_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire dcrt_cmd_t                  cmd,
	output dcrt_sts_t                       sts,
	input  wire logic [KIND_W-1:0]          in_kind,
	input  wire logic [BYTE_COUNT_BITS-1:0] in_bytes,
	input  wire logic [LIMIT_W-1:0]         speed_limit,
	input  wire logic [WIN_W-1:0]           cycle_period,
	input  wire logic [WIN_W-1:0]           recheck,
	input  wire logic [WIN_W-1:0]           start_delay,
	output logic                            run_enable,
	output logic                            check_done,
	output logic [WIN_W-1:0]                on_ticks,
	output logic [WIN_W-1:0]                off_ticks
);

	// Numerator width covers both 1000 * delta and elapsed * period.
	localparam int PROD2_W = ELAPSED_W + WIN_W;
	localparam int NUM_W   = (BYTE_COUNT_BITS + 10 > PROD2_W) ? BYTE_COUNT_BITS + 10 : PROD2_W;

	// Throttle state.
	phase_t                     phase_q;
	logic [WIN_W-1:0]           countdown_q;
	logic [ELAPSED_W-1:0]       elapsed_q;
	logic [BYTE_COUNT_BITS-1:0] last_bytes_q;
	logic [WIN_W-1:0]           on_q;
	logic [WIN_W-1:0]           off_q;
	logic                       running_q;
	logic                       checked_q;

	// Request and arithmetic registers.
	logic [KIND_W-1:0]          kind_q;
	logic [BYTE_COUNT_BITS-1:0] bytes_q;
	logic [NUM_W-1:0]           prod_q;

	// Result register.
	logic                       out_run_q;
	logic                       out_chk_q;
	logic [WIN_W-1:0]           out_on_q;
	logic [WIN_W-1:0]           out_off_q;

	logic [BYTE_COUNT_BITS-1:0] delta;
	logic [NUM_W-1:0]           delta_x;
	logic [NUM_W-1:0]           scaled;
	logic [PROD2_W-1:0]         period_prod;
	logic [ELAPSED_W-1:0]       elapsed_inc;
	logic                       cd_expire;
	logic [ELAPSED_W-1:0]       div_quo;
	logic                       div_busy;
	logic [LIMIT_W-1:0]         div_den;
	logic [ELAPSED_W-1:0]       exp_val;
	logic [WIN_W-1:0]           on_new;
	logic [WIN_W-1:0]           off_new;

	// Bytes moved since the last check, wrapping at the counter width, times
	// 1000 as 1024 - 16 - 8.
	assign delta   = bytes_q - last_bytes_q;
	assign delta_x = NUM_W'(delta);
	assign scaled  = (delta_x << 10) - (delta_x << 4) - (delta_x << 3);

	// Elapsed ticks times the cycle period for the on window.
	assign period_prod = {{WIN_W{1'b0}}, elapsed_q} * {{ELAPSED_W{1'b0}}, cycle_period};

	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 31'd1;
	assign cd_expire   = (countdown_q <= 16'd1);

	// The second division runs by the expected time left from the first.
	assign div_den = cmd.den_sel ? {1'b0, div_quo} : speed_limit;

	dcrt_div #(
		.NUM_W (NUM_W),
		.DEN_W (LIMIT_W),
		.QUO_W (ELAPSED_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (prod_q),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	// Expected time is zero when throttling is disabled.
	assign exp_val = (speed_limit == '0) ? '0 : div_quo;
	assign on_new  = div_quo[WIN_W-1:0];
	assign off_new = cycle_period - on_new;

	// Status toward the controller.
	assign sts.need_check = (kind_q == KIND_TICK) && (phase_q != PH_IDLE) &&
		(phase_q != PH_SUSP) && cd_expire;
	assign sts.div_busy   = div_busy;
	assign sts.throttle   = (exp_val > elapsed_q);

	// Throttle state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			countdown_q  <= '0;
			elapsed_q    <= '0;
			last_bytes_q <= '0;
			on_q         <= '0;
			off_q        <= '0;
			running_q    <= 1'b1;
			checked_q    <= 1'b0;
		end else begin
			if (cmd.eval) begin
				checked_q <= 1'b0;
				case (kind_q)
					KIND_START: begin
						running_q <= 1'b1;
						if (speed_limit == '0) begin
							phase_q <= PH_IDLE;
						end else begin
							last_bytes_q <= bytes_q;
							elapsed_q    <= '0;
							on_q         <= '0;
							off_q        <= '0;
							phase_q      <= PH_WAIT;
							countdown_q  <= start_delay;
						end
					end
					KIND_TICK: begin
						if (phase_q != PH_IDLE) begin
							elapsed_q <= elapsed_inc;
							if (cd_expire) begin
								countdown_q <= '0;
								if (phase_q == PH_SUSP) begin
									running_q   <= 1'b1;
									elapsed_q   <= '0;
									phase_q     <= PH_RESUME;
									countdown_q <= on_q;
								end
							end else begin
								countdown_q <= countdown_q - 16'd1;
							end
						end
					end
					KIND_FINISH: begin
						phase_q   <= PH_IDLE;
						running_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
			if (cmd.mul1) begin
				last_bytes_q <= bytes_q;
			end
			// Under the limit: run and check again later.
			if (cmd.cmp && !sts.throttle) begin
				elapsed_q   <= '0;
				running_q   <= 1'b1;
				phase_q     <= PH_WAIT;
				countdown_q <= recheck;
				checked_q   <= 1'b1;
			end
			// Over the limit: suspend for the off window.
			if (cmd.win) begin
				on_q        <= on_new;
				off_q       <= off_new;
				running_q   <= 1'b0;
				phase_q     <= PH_SUSP;
				countdown_q <= off_new;
				elapsed_q   <= '0;
				checked_q   <= 1'b1;
			end
		end
	end

	// Request capture and product register.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= in_kind;
			bytes_q <= in_bytes;
		end
		if (cmd.mul1) begin
			prod_q <= scaled;
		end else if (cmd.mul2) begin
			prod_q <= NUM_W'(period_prod);
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_run_q <= running_q;
			out_chk_q <= checked_q;
			out_on_q  <= on_q;
			out_off_q <= off_q;
		end
	end

	assign run_enable = out_run_q;
	assign check_done = out_chk_q;
	assign on_ticks   = out_on_q;
	assign off_ticks  = out_off_q;

endmodule

`default_nettype wire

[rtl/dcrt_ctrl.sv]
// Controller of the duty cycle rate throttle: sequences evaluation, the
// rate check steps and the result handshake.
// Depends on dcrt_pkg.
`default_nettype none

module dcrt_ctrl import dcrt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_valid,
	output logic           s_ready,
	output logic           m_valid,
	input  wire logic      m_ready,
	input  wire dcrt_sts_t sts,
	output dcrt_cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL1,
		ST_DIV1_GO,
		ST_DIV1,
		ST_CMP,
		ST_MUL2,
		ST_DIV2_GO,
		ST_DIV2,
		ST_WIN,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   m_valid_q;
	logic   slot_free;

	// The result register can take a new result when empty or being drained.
	assign slot_free = !m_valid_q || m_ready;
	assign s_ready   = (state_q == ST_IDLE);
	assign m_valid   = m_valid_q;

	// Commands decoded from the state.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:    cmd.capture   = s_valid;
			ST_EVAL:    cmd.eval      = 1'b1;
			ST_MUL1:    cmd.mul1      = 1'b1;
			ST_DIV1_GO: cmd.div_start = 1'b1;
			ST_CMP:     cmd.cmp       = 1'b1;
			ST_MUL2:    cmd.mul2      = 1'b1;
			ST_DIV2_GO: begin
				cmd.div_start = 1'b1;
				cmd.den_sel   = 1'b1;
			end
			ST_WIN:     cmd.win       = 1'b1;
			ST_OUT:     cmd.load_out  = slot_free;
			default: begin
			end
		endcase
	end

	// State and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && slot_free) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_valid) state_q <= ST_EVAL;
				end
				ST_EVAL:    state_q <= sts.need_check ? ST_MUL1 : ST_OUT;
				ST_MUL1:    state_q <= ST_DIV1_GO;
				ST_DIV1_GO: state_q <= ST_DIV1;
				ST_DIV1: begin
					if (!sts.div_busy) state_q <= ST_CMP;
				end
				ST_CMP:     state_q <= sts.throttle ? ST_MUL2 : ST_OUT;
				ST_MUL2:    state_q <= ST_DIV2_GO;
				ST_DIV2_GO: state_q <= ST_DIV2;
				ST_DIV2: begin
					if (!sts.div_busy) state_q <= ST_WIN;
				end
				ST_WIN:     state_q <= ST_OUT;
				ST_OUT: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

	// A division is only started on an idle divider, and it then runs.
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("division started while the divider is busy");

	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> sts.div_busy)
		else $error("divider did not take the start request");

	// The comparison uses a finished quotient.
	a_cmp_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> !sts.div_busy)
		else $error("rate comparison while the divider is busy");

	// Evaluation always follows an accepted request.
	a_eval_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |-> $past(s_valid && s_ready))
		else $error("evaluation without an accepted request");

endmodule

`default_nettype wire

[tb/sv/duty_cycle_rate_throttle_core_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for duty_cycle_rate_throttle_core: directed table, then random
// start/tick/finish traffic, each result checked against a cycle-free throttle predictor.
// Depends on dcrt_pkg and the duty_cycle_rate_throttle_core RTL.

module duty_cycle_rate_throttle_core_test;
	import dcrt_pkg::*;

	localparam int BC_W            = BYTE_COUNT_BITS_DEF;
	localparam int S_TDATA_W       = ((BC_W + 7) / 8) * 8;
	localparam int RAND_PHASES     = 7;
	localparam int PHASE_ITEMS     = 250;
	localparam int PRESSURE_AT     = 400;
	localparam int PRESSURE_CYCLES = 600;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int TAIL_CYCLES     = 150;
	localparam int DIR_ROWS        = 32;

	// The fourth request code, which the block ignores.
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	// One result: the gate state reported for a request.
	typedef struct packed {
		logic        run_enable;
		logic        check_done;
		logic [15:0] on_ticks;
		logic [15:0] off_ticks;
	} gate_t;

	typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

	// A directed row either writes a register (sel is the index) or sends a request
	// (sel is the kind); typed rows carry a hand-written result.
	typedef struct packed {
		row_kind_t   rk;
		logic [1:0]  sel;
		logic [47:0] val;
		bit          typed;
		gate_t       res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [KIND_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;

	// Predictor copy of the configuration and the throttle state.
	logic [31:0] cfg_limit;
	logic [15:0] cfg_period;
	logic [15:0] cfg_recheck;
	logic [15:0] cfg_start_delay;
	phase_t      thr_phase;
	logic [15:0] thr_countdown;
	logic [30:0] thr_elapsed;
	logic [47:0] thr_last_bytes;
	logic [15:0] thr_on;
	logic [15:0] thr_off;
	logic        thr_running;

	gate_t gate_queue[$];
	int error_count = 0;
	int rx_count = 0;
	bit no_gap = 1'b0;
	dir_row_t directed_rows [DIR_ROWS];

	duty_cycle_rate_throttle_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Advance the throttle by one request and return the gate state it reports.
	function automatic gate_t advance_throttle(logic [1:0] kind, logic [47:0] bytes);
		gate_t res;
		logic checked;
		logic [47:0] delta;
		longint unsigned delta64, lim64, el64, per64, max64, q, r, ems, on64;
		checked = 1'b0;
		case (kind)
			KIND_START: begin
				thr_running = 1'b1;
				if (cfg_limit == 32'd0) begin
					thr_phase = PH_IDLE;
				end else begin
					thr_last_bytes = bytes;
					thr_elapsed = '0;
					thr_on = '0;
					thr_off = '0;
					thr_phase = PH_WAIT;
					thr_countdown = cfg_start_delay;
				end
			end
			KIND_TICK: begin
				if (thr_phase != PH_IDLE) begin
					if (thr_elapsed < ELAPSED_MAX)
						thr_elapsed = thr_elapsed + 31'd1;
					if (thr_countdown <= 16'd1) begin
						thr_countdown = '0;
						if (thr_phase == PH_SUSP) begin
							// Suspend window over: run for the on window.
							thr_running = 1'b1;
							thr_elapsed = '0;
							thr_phase = PH_RESUME;
							thr_countdown = thr_on;
						end else begin
							// Rate check: time the bytes moved should have taken.
							checked = 1'b1;
							delta = bytes - thr_last_bytes;
							delta64 = {16'd0, delta};
							lim64 = {32'd0, cfg_limit};
							el64 = {33'd0, thr_elapsed};
							per64 = {48'd0, cfg_period};
							max64 = {33'd0, ELAPSED_MAX};
							if (cfg_limit == 32'd0) begin
								ems = 64'd0;
							end else begin
								q = delta64 / lim64;
								r = delta64 % lim64;
								if (q > 64'd2147483) begin
									ems = max64;
								end else begin
									ems = q * 64'd1000 + (r * 64'd1000) / lim64;
									if (ems > max64)
										ems = max64;
								end
							end
							thr_last_bytes = bytes;
							thr_elapsed = '0;
							if (ems > el64) begin
								on64 = (el64 * per64) / ems;
								thr_on = on64[15:0];
								thr_off = cfg_period - thr_on;
								thr_running = 1'b0;
								thr_phase = PH_SUSP;
								thr_countdown = thr_off;
							end else begin
								thr_running = 1'b1;
								thr_phase = PH_WAIT;
								thr_countdown = cfg_recheck;
							end
						end
					end else begin
						thr_countdown = thr_countdown - 16'd1;
					end
				end
			end
			KIND_FINISH: begin
				thr_phase = PH_IDLE;
				thr_running = 1'b1;
			end
			default: ;
		endcase
		res.run_enable = thr_running;
		res.check_done = checked;
		res.on_ticks = thr_on;
		res.off_ticks = thr_off;
		return res;
	endfunction

	// One configuration access: setup cycle, then access cycle until pready.
	task automatic apb_access(logic wr, logic [1:0] idx, logic [31:0] wdata,
			output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Read a register back and compare it with the value it should hold.
	task automatic reg_check(logic [1:0] idx, logic [31:0] value);
		logic [31:0] rd;
		apb_access(1'b0, idx, 32'd0, rd);
		if (rd !== value) begin
			$error("register %0d: expected %0h, got %0h", idx, value, rd);
			error_count++;
		end
	endtask

	// Write a register, mirror it in the predictor and read it back.
	task automatic cfg_set(logic [1:0] idx, logic [31:0] value);
		logic [31:0] unused_rd;
		apb_access(1'b1, idx, value, unused_rd);
		case (idx)
			REG_SPEED_LIMIT:  cfg_limit = value;
			REG_CYCLE_PERIOD: cfg_period = value[15:0];
			REG_RECHECK:      cfg_recheck = value[15:0];
			default:          cfg_start_delay = value[15:0];
		endcase
		reg_check(idx, value);
	endtask

	// Offer one request after a random gap and record its predicted result once taken.
	task automatic send_item(logic [1:0] kind, logic [47:0] bytes, bit typed,
			gate_t typed_res);
		int gap;
		gate_t pred;
		gap = no_gap ? 0 : int'($urandom_range(0, 11));
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= bytes;
		do @(posedge clk); while (!s_axis_tready);
		pred = advance_throttle(kind, bytes);
		gate_queue.push_back(typed ? typed_res : pred);
	endtask

	// Stop offering and wait until every predicted result has come out.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (gate_queue.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Stimulus: reset, directed table, then random phases under varied settings.
	initial begin
		int ph, counted, r, f;
		logic [31:0] lim;
		logic [15:0] per, rec, sd;
		logic [47:0] cur_bytes;
		logic [63:0] rnd64, step64;
		logic [1:0] kind;
		directed_rows = '{
			'{ROW_ITEM, KIND_START,  48'd0,               1'b1, '{1'b1, 1'b0, 16'd0, 16'd0}},
			'{ROW_ITEM, KIND_TICK,   48'hFFFF_FFFF_FFFF,  1'b1, '{1'b1, 1'b0, 16'd0, 16'd0}},
			'{ROW_ITEM, KIND_UNUSED, 48'h5555_5555_5555,  1'b1, '{1'b1, 1'b0, 16'd0, 16'd0}},
			'{ROW_ITEM, KIND_FINISH, 48'd0,               1'b1, '{1'b1, 1'b0, 16'd0, 16'd0}},
			'{ROW_CFG,  REG_SPEED_LIMIT,  48'd1000,       1'b0, '0},
			'{ROW_CFG,  REG_CYCLE_PERIOD, 48'd10,         1'b0, '0},
			'{ROW_CFG,  REG_RECHECK,      48'd2,          1'b0, '0},
			'{ROW_CFG,  REG_START_DELAY,  48'd1,          1'b0, '0},
			'{ROW_ITEM, KIND_START,  48'd0,               1'b1, '{1'b1, 1'b0, 16'd0, 16'd0}},
			'{ROW_ITEM, KIND_TICK,   48'd100,             1'b1, '{1'b0, 1'b1, 16'd0, 16'd10}},
			'{ROW_ITEM, KIND_START,  48'd50,              1'b1, '{1'b1, 1'b0, 16'd0, 16'd0}},
			'{ROW_ITEM, KIND_TICK,   48'd50,              1'b1, '{1'b1, 1'b1, 16'd0, 16'd0}},
			'{ROW_ITEM, KIND_TICK,   48'd50,              1'b0, '0},
			'{ROW_ITEM, KIND_TICK,   48'd40,              1'b1, '{1'b0, 1'b1, 16'd0, 16'd10}},
			'{ROW_ITEM, KIND_FINISH, 48'd0,               1'b1, '{1'b1, 1'b0, 16'd0, 16'd10}},
			'{ROW_CFG,  REG_SPEED_LIMIT,  48'hFFFF_FFFF,  1'b0, '0},
			'{ROW_CFG,  REG_CYCLE_PERIOD, 48'd0,          1'b0, '0},
			'{ROW_CFG,  REG_RECHECK,      48'd0,          1'b0, '0},
			'{ROW_CFG,  REG_START_DELAY,  48'd0,          1'b0, '0},
			'{ROW_ITEM, KIND_START,  48'd0,               1'b1, '{1'b1, 1'b0, 16'd0, 16'd0}},
			'{ROW_ITEM, KIND_TICK,   48'hFFFF_FFFF_FFFF,  1'b1, '{1'b0, 1'b1, 16'd0, 16'd0}},
			'{ROW_ITEM, KIND_TICK,   48'hFFFF_FFFF_FFFF,  1'b1, '{1'b1, 1'b0, 16'd0, 16'd0}},
			'{ROW_ITEM, KIND_TICK,   48'hFFFF_FFFF_FFFF,  1'b1, '{1'b1, 1'b1, 16'd0, 16'd0}},
			'{ROW_ITEM, KIND_TICK,   48'hFFFF_FFFF_FFFF,  1'b1, '{1'b1, 1'b1, 16'd0, 16'd0}},
			'{ROW_ITEM, KIND_UNUSED, 48'hAAAA_AAAA_AAAA,  1'b0, '0},
			'{ROW_ITEM, KIND_FINISH, 48'd0,               1'b1, '{1'b1, 1'b0, 16'd0, 16'd0}},
			'{ROW_CFG,  REG_SPEED_LIMIT,  48'd1,          1'b0, '0},
			'{ROW_CFG,  REG_CYCLE_PERIOD, 48'd65535,      1'b0, '0},
			'{ROW_CFG,  REG_RECHECK,      48'd65535,      1'b0, '0},
			'{ROW_CFG,  REG_START_DELAY,  48'd65535,      1'b0, '0},
			'{ROW_ITEM, KIND_START,  48'h8000_0000_0000,  1'b1, '{1'b1, 1'b0, 16'd0, 16'd0}},
			'{ROW_ITEM, KIND_TICK,   48'h8000_0000_0001,  1'b1, '{1'b1, 1'b0, 16'd0, 16'd0}}
		};

		// Predictor starts from the reset state.
		cfg_limit = SPEED_LIMIT_RST;
		cfg_period = CYCLE_PERIOD_RST;
		cfg_recheck = RECHECK_RST;
		cfg_start_delay = START_DELAY_RST;
		thr_phase = PH_IDLE;
		thr_countdown = '0;
		thr_elapsed = '0;
		thr_last_bytes = '0;
		thr_on = '0;
		thr_off = '0;
		thr_running = 1'b1;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		reg_check(REG_SPEED_LIMIT, SPEED_LIMIT_RST);
		reg_check(REG_CYCLE_PERIOD, {16'd0, CYCLE_PERIOD_RST});
		reg_check(REG_RECHECK, {16'd0, RECHECK_RST});
		reg_check(REG_START_DELAY, {16'd0, START_DELAY_RST});

		// Directed part: registers are only written once the block has gone quiet.
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (directed_rows[i].rk == ROW_CFG) begin
				drain();
				cfg_set(directed_rows[i].sel, directed_rows[i].val[31:0]);
			end else begin
				send_item(directed_rows[i].sel, directed_rows[i].val,
					directed_rows[i].typed, directed_rows[i].res);
			end
		end

		// Random part: each phase picks a setting, then mostly well-formed transfers.
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			drain();
			per = 16'($urandom_range(1, 40));
			rec = 16'($urandom_range(1, 20));
			sd = 16'($urandom_range(0, 10));
			case (ph)
				0, 5:    lim = $urandom_range(1000, 100000);
				1:       lim = $urandom;
				2: begin
					lim = 32'hFFFF_FFFF;
					per = '0;
					rec = '0;
					sd = '0;
				end
				3: begin
					lim = 32'd1;
					per = 16'hFFFF;
					rec = 16'd1;
					sd = 16'd1;
				end
				4: begin
					lim = 32'd0;
					per = 16'($urandom);
					rec = 16'($urandom);
					sd = 16'($urandom);
				end
				default: begin
					lim = $urandom_range(500, 20000000);
					per = 16'($urandom_range(100, 1000));
				end
			endcase
			cfg_set(REG_SPEED_LIMIT, lim);
			cfg_set(REG_CYCLE_PERIOD, {16'd0, per});
			cfg_set(REG_RECHECK, {16'd0, rec});
			cfg_set(REG_START_DELAY, {16'd0, sd});
			no_gap = (ph == 5);

			rnd64 = {$urandom, $urandom};
			cur_bytes = rnd64[47:0];
			send_item(KIND_START, cur_bytes, 1'b0, '0);
			counted = 1;
			while (counted < PHASE_ITEMS) begin
				r = int'($urandom_range(0, 99));
				rnd64 = {$urandom, $urandom};
				if (r < 2) begin
					kind = KIND_START;
					if (r == 0)
						cur_bytes = rnd64[47:0];
				end else if (r < 3) begin
					kind = KIND_FINISH;
				end else if (r < 6) begin
					kind = KIND_UNUSED;
				end else if (r < 8) begin
					// Noise: the byte count jumps anywhere, backwards included.
					kind = KIND_TICK;
					cur_bytes = rnd64[47:0];
				end else begin
					// Progress at a rate scattered around the limit.
					kind = KIND_TICK;
					f = int'($urandom_range(0, 4));
					step64 = ({32'd0, lim} * 64'(f)) / 64'd2000 + 64'($urandom_range(0, 3));
					cur_bytes = cur_bytes + step64[47:0];
				end
				send_item(kind, (kind == KIND_UNUSED) ? rnd64[47:0] : cur_bytes, 1'b0, '0);
				if (kind != KIND_UNUSED)
					counted++;
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("duty_cycle_rate_throttle_core_test: clean");
		else
			$display("duty_cycle_rate_throttle_core_test: errors");
		$finish;
	end

	// Result side: random stalls, one long hold-off, and a stretch with no stalls.
	initial begin
		int stall;
		gate_t want;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (rx_count == PRESSURE_AT)
				stall = PRESSURE_CYCLES;
			else if (rx_count >= 900 && rx_count < 1100)
				stall = 0;
			else
				stall = int'($urandom_range(0, 11));
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			rx_count++;
			if (gate_queue.size() == 0) begin
				$error("result with no request waiting for it");
				error_count++;
			end else begin
				want = gate_queue.pop_front();
				if (m_axis_tdata[0] !== want.run_enable) begin
					$error("run_enable: expected %0d, got %0d", want.run_enable,
						m_axis_tdata[0]);
					error_count++;
				end
				if (m_axis_tuser[0] !== want.check_done) begin
					$error("check_done: expected %0d, got %0d", want.check_done,
						m_axis_tuser[0]);
					error_count++;
				end
				if (m_axis_tdata[16:1] !== want.on_ticks) begin
					$error("on_ticks: expected %0d, got %0d", want.on_ticks,
						m_axis_tdata[16:1]);
					error_count++;
				end
				if (m_axis_tdata[32:17] !== want.off_ticks) begin
					$error("off_ticks: expected %0d, got %0d", want.off_ticks,
						m_axis_tdata[32:17]);
					error_count++;
				end
			end
		end
	end

	// Watchdog: ends the run when nothing moves on any port for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel
					|| !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("duty_cycle_rate_throttle_core_test: errors");
		$finish;
	end

endmodule
